@@ hdl/qrnn_pkg.sv @@
// Shared types, codes and the tanh activation table of the QRNN word scorer.
package qrnn_pkg;

  localparam int MAX_DIMS   = 64;
  localparam int MAX_CELLS  = 64;
  localparam int MAX_WINDOW = 4;
  localparam int GATES      = 3;

  localparam logic [63:0] TANH_STEP_Q30 = 64'd67021619;

  typedef enum logic [1:0] {
    OP_CONV_WR = 2'd0,
    OP_BIAS_WR = 2'd1,
    OP_OUTW_WR = 2'd2,
    OP_ELEM    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DIMS   = 2'd0,
    REG_CELLS  = 2'd1,
    REG_WINDOW = 2'd2,
    REG_BIAS   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    GATE_Z = 2'd0,
    GATE_F = 2'd1,
    GATE_O = 2'd2
  } gate_e;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_TAP  = 3'd1,
    MUL_FC   = 3'd2,
    MUL_FZ   = 3'd3,
    MUL_CO   = 3'd4,
    MUL_CW   = 3'd5
  } mul_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BIAS, ST_TAP, ST_DRN1, ST_DRN2, ST_GRND, ST_GACT,
    ST_CRD, ST_FC, ST_FZ, ST_CWT, ST_CUPD, ST_CO, ST_COWT, ST_CORND,
    ST_CW, ST_SWT, ST_SRND, ST_SCORE
  } state_e;

  typedef struct packed {
    logic    take;
    logic    bias_rd;
    logic    tap_rd;
    mul_op_e mul_op;
    logic    gate_rnd;
    logic    sum_rnd;
    logic    gate_act;
    logic    cell_rd;
    logic    cell_wr;
    logic    co_rnd;
    logic    out_load;
    logic    word_done;
  } cmd_t;

  typedef logic signed [15:0] tanh_rom_t [256];

  // Builds the table by the tanh addition recursion, with a shift-subtract divide.
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] qv;
    t = 64'd0;
    rom[128] = 16'sd0;
    for (int k = 1; k <= 128; k++) begin
      num = (t + TANH_STEP_Q30) << 30;
      den = (64'd1 << 30) + ((t * TANH_STEP_Q30) >> 30);
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], num[i]};
        if (rem >= den) begin
          rem = rem - den;
          quo[i] = 1'b1;
        end
      end
      t = quo;
      qv = (t * 64'd4096 + (64'd1 << 29)) >> 30;
      if (k < 128) begin
        rom[128 + k] = $signed(qv[15:0]);
      end
      rom[128 - k] = -$signed(qv[15:0]);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
    logic [16:0] s;
    logic [7:0]  idx;
    s   = {x[15], x} + 17'd32896;
    idx = s[16] ? 8'hFF : s[15:8];
    return TANH_ROM[idx];
  endfunction

  function automatic logic [12:0] sigmoid_q(input logic signed [15:0] x);
    logic signed [15:0] h;
    logic signed [15:0] t;
    logic [16:0]        s;
    h = x >>> 1;
    t = tanh_q(h);
    s = 17'd4097 + {t[15], t};
    return s[13:1];
  endfunction

endpackage

@@ hdl/qrnn_ctrl.sv @@
// Sequencer of the QRNN word scorer: walks cells, gates and convolution taps.
module qrnn_ctrl #(
  parameter int MaxDims   = qrnn_pkg::MAX_DIMS,
  parameter int MaxCells  = qrnn_pkg::MAX_CELLS,
  parameter int MaxWindow = qrnn_pkg::MAX_WINDOW,
  localparam int KW  = (MaxDims > 1) ? $clog2(MaxDims) : 1,
  localparam int CIW = (MaxCells > 1) ? $clog2(MaxCells) : 1,
  localparam int WW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic             word_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [6:0]       dims_i,
  input  logic [6:0]       cells_i,
  input  logic [2:0]       window_i,
  output qrnn_pkg::cmd_t   cmd_o,
  output logic [CIW-1:0]   c_o,
  output logic [1:0]       g_o,
  output logic [KW-1:0]    k_o,
  output logic [WW-1:0]    m_o,
  output logic [WW-1:0]    age_o
);
  import qrnn_pkg::*;

  state_e         state_q, state_d;
  logic [CIW-1:0] c_q, c_d;
  logic [1:0]     g_q, g_d;
  logic [KW-1:0]  k_q, k_d;
  logic [WW-1:0]  m_q, m_d;
  logic           out_valid_q, out_valid_d;
  logic [KW:0]    dims_eff;
  logic [CIW:0]   cells_eff;
  logic [WW:0]    win_eff;
  logic [WW:0]    age_full;
  logic           take;
  logic           word_in;
  logic           k_last, m_last, c_last;
  logic           out_free;

  assign dims_eff  = (int'(dims_i) > MaxDims) ? (KW+1)'(MaxDims) : (KW+1)'(dims_i);
  assign cells_eff = (int'(cells_i) > MaxCells) ? (CIW+1)'(MaxCells) : (CIW+1)'(cells_i);
  always_comb begin
    if (window_i == 3'd0) begin
      win_eff = (WW+1)'(1);
    end else if (int'(window_i) > MaxWindow) begin
      win_eff = (WW+1)'(MaxWindow);
    end else begin
      win_eff = (WW+1)'(window_i);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign word_in    = take && (opcode_i == OP_ELEM) && word_end_i;
  assign k_last     = ({1'b0, k_q} == dims_eff - (KW+1)'(1));
  assign m_last     = ({1'b0, m_q} == win_eff - (WW+1)'(1));
  assign c_last     = ({1'b0, c_q} == cells_eff - (CIW+1)'(1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign age_full   = win_eff - (WW+1)'(1) - {1'b0, m_q};

  assign c_o   = c_q;
  assign g_o   = g_q;
  assign k_o   = k_q;
  assign m_o   = m_q;
  assign age_o = age_full[WW-1:0];
  assign out_valid_o = out_valid_q;

  // Next state and loop counters.
  always_comb begin
    state_d = state_q;
    c_d = c_q;
    g_d = g_q;
    k_d = k_q;
    m_d = m_q;
    unique case (state_q)
      ST_IDLE: begin
        if (word_in) begin
          c_d = '0;
          g_d = '0;
          k_d = '0;
          m_d = '0;
          state_d = (cells_eff == '0) ? ST_SWT : ST_BIAS;
        end
      end
      ST_BIAS: begin
        k_d = '0;
        m_d = '0;
        state_d = (dims_eff == '0) ? ST_DRN1 : ST_TAP;
      end
      ST_TAP: begin
        if (k_last) begin
          k_d = '0;
          m_d = m_q + WW'(1);
          if (m_last) begin
            state_d = ST_DRN1;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DRN1:  state_d = ST_DRN2;
      ST_DRN2:  state_d = ST_GRND;
      ST_GRND:  state_d = ST_GACT;
      ST_GACT: begin
        if (g_q == GATE_O) begin
          state_d = ST_CRD;
        end else begin
          g_d = g_q + 2'd1;
          state_d = ST_BIAS;
        end
      end
      ST_CRD:   state_d = ST_FC;
      ST_FC:    state_d = ST_FZ;
      ST_FZ:    state_d = ST_CWT;
      ST_CWT:   state_d = ST_CUPD;
      ST_CUPD:  state_d = ST_CO;
      ST_CO:    state_d = ST_COWT;
      ST_COWT:  state_d = ST_CORND;
      ST_CORND: state_d = ST_CW;
      ST_CW: begin
        if (c_last) begin
          state_d = ST_SWT;
        end else begin
          c_d = c_q + CIW'(1);
          g_d = '0;
          state_d = ST_BIAS;
        end
      end
      ST_SWT:   state_d = ST_SRND;
      ST_SRND:  state_d = ST_SCORE;
      ST_SCORE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op = MUL_NONE;
    cmd_o.take = take;
    unique case (state_q)
      ST_BIAS:  cmd_o.bias_rd  = 1'b1;
      ST_TAP:   cmd_o.tap_rd   = 1'b1;
      ST_GRND:  cmd_o.gate_rnd = 1'b1;
      ST_GACT:  cmd_o.gate_act = 1'b1;
      ST_CRD:   cmd_o.cell_rd  = 1'b1;
      ST_FC:    cmd_o.mul_op   = MUL_FC;
      ST_FZ:    cmd_o.mul_op   = MUL_FZ;
      ST_CUPD:  cmd_o.cell_wr  = 1'b1;
      ST_CO:    cmd_o.mul_op   = MUL_CO;
      ST_CORND: cmd_o.co_rnd   = 1'b1;
      ST_CW:    cmd_o.mul_op   = MUL_CW;
      ST_SRND:  cmd_o.sum_rnd  = 1'b1;
      ST_SCORE: begin
        cmd_o.out_load  = out_free;
        cmd_o.word_done = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      g_q         <= '0;
      k_q         <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      g_q         <= g_d;
      k_q         <= k_d;
      m_q         <= m_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/qrnn_dp.sv @@
// Datapath of the QRNN word scorer: memories, shared multiply-accumulate, gates.
module qrnn_dp #(
  parameter int MaxDims   = qrnn_pkg::MAX_DIMS,
  parameter int MaxCells  = qrnn_pkg::MAX_CELLS,
  parameter int MaxWindow = qrnn_pkg::MAX_WINDOW,
  localparam int KW  = (MaxDims > 1) ? $clog2(MaxDims) : 1,
  localparam int CIW = (MaxCells > 1) ? $clog2(MaxCells) : 1,
  localparam int WW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qrnn_pkg::cmd_t     cmd_i,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        slot_i,
  input  logic signed [15:0] value_i,
  input  logic               sentence_start_i,
  input  logic               word_end_i,
  input  logic signed [15:0] score_bias_i,
  input  logic [CIW-1:0]     c_i,
  input  logic [1:0]         g_i,
  input  logic [KW-1:0]      k_i,
  input  logic [WW-1:0]      m_i,
  input  logic [WW-1:0]      age_i,
  output logic [12:0]        score_o,
  output logic [15:0]        word_number_o
);
  import qrnn_pkg::*;

  localparam int ConvDepth = MaxDims * MaxWindow * GATES * MaxCells;
  localparam int CAW       = $clog2(ConvDepth);
  localparam int BiasDepth = GATES * MaxCells;
  localparam int BAW       = $clog2(BiasDepth);
  localparam int HistDepth = MaxWindow * MaxDims;
  localparam int HAW       = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int AW        = 34 + $clog2(HistDepth + 1);
  localparam int SW        = 35 + $clog2(MaxCells + 1);

  logic signed [15:0] conv_mem [ConvDepth];
  logic signed [15:0] bias_mem [BiasDepth];
  logic signed [15:0] outw_mem [MaxCells];
  logic signed [15:0] hist_mem [HistDepth];
  logic signed [15:0] cell_mem [MaxCells];

  logic [HistDepth-1:0] hv_q, hv_d;
  logic [MaxCells-1:0]  cv_q, cv_d;
  logic [WW-1:0]        hd_q, hd_nx;
  logic [15:0]          wcnt_q;

  logic signed [15:0] w_rd_q, h_rd_q, b_rd_q, c_rd_q, wo_rd_q;
  logic               h_rv_q, c_rv_q;
  logic               tap_v_q, bias_v_q;

  logic signed [AW-1:0] acc_q, acc_rnd;
  logic signed [SW-1:0] sum_q, sum_rnd;
  logic signed [15:0]   acc_sat, sum_sat;
  logic signed [34:0]   prod_q;
  mul_op_e              prod_op_q, mop;
  logic signed [17:0]   mul_a;
  logic signed [16:0]   mul_b;

  logic signed [15:0] x_q, z_q, cell_new_q;
  logic [12:0]        f_q, o_q;
  logic signed [16:0] co_q;
  logic [12:0]        score_q;
  logic [15:0]        wn_q;

  logic            is_elem, conv_we, bias_we, outw_we, hist_we, sstart;
  logic [HAW-1:0]  h_waddr, h_raddr;
  logic [CAW-1:0]  conv_raddr;
  logic [BAW-1:0]  bias_raddr;
  logic [WW:0]     row_sum;
  logic [WW-1:0]   row;

  assign is_elem = cmd_i.take && (opcode_i == OP_ELEM);
  assign sstart  = is_elem && sentence_start_i;
  assign conv_we = cmd_i.take && (opcode_i == OP_CONV_WR) && (int'(slot_i) < ConvDepth);
  assign bias_we = cmd_i.take && (opcode_i == OP_BIAS_WR) && (int'(slot_i) < BiasDepth);
  assign outw_we = cmd_i.take && (opcode_i == OP_OUTW_WR) && (int'(slot_i) < MaxCells);
  assign hist_we = is_elem && (int'(slot_i) < MaxDims);
  assign h_waddr = HAW'(int'(hd_q) * MaxDims + int'(slot_i));

  // Physical row of a word age places back in the circular history.
  assign row_sum = {1'b0, hd_q} + {1'b0, age_i};
  assign row     = (int'(row_sum) >= MaxWindow) ? WW'(int'(row_sum) - MaxWindow)
                                                : row_sum[WW-1:0];
  assign h_raddr    = HAW'(int'(row) * MaxDims + int'(k_i));
  assign conv_raddr = CAW'(((int'(k_i) * MaxWindow + int'(m_i)) * GATES + int'(g_i))
                           * MaxCells + int'(c_i));
  assign bias_raddr = BAW'(int'(g_i) * MaxCells + int'(c_i));
  assign hd_nx      = (hd_q == '0) ? WW'(MaxWindow - 1) : hd_q - WW'(1);

  always_ff @(posedge clk_i) begin
    if (conv_we) begin
      conv_mem[CAW'(slot_i)] <= value_i;
    end
    if (cmd_i.tap_rd) begin
      w_rd_q <= conv_mem[conv_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bias_we) begin
      bias_mem[BAW'(slot_i)] <= value_i;
    end
    if (cmd_i.bias_rd) begin
      b_rd_q <= bias_mem[bias_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (outw_we) begin
      outw_mem[CIW'(slot_i)] <= value_i;
    end
    if (cmd_i.cell_rd) begin
      wo_rd_q <= outw_mem[c_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[h_waddr] <= value_i;
    end
    if (cmd_i.tap_rd) begin
      h_rd_q <= hist_mem[h_raddr];
      h_rv_q <= hv_q[h_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_wr) begin
      cell_mem[c_i] <= acc_sat;
    end
    if (cmd_i.cell_rd) begin
      c_rd_q <= cell_mem[c_i];
      c_rv_q <= cv_q[c_i];
    end
  end

  // Valid bits stand in for the zeroed history rows and cells.
  always_comb begin
    hv_d = hv_q;
    cv_d = cv_q;
    if (sstart) begin
      hv_d = '0;
      cv_d = '0;
    end
    if (hist_we) begin
      hv_d[h_waddr] = 1'b1;
    end
    if (cmd_i.cell_wr) begin
      cv_d[c_i] = 1'b1;
    end
    if (cmd_i.word_done) begin
      for (int i = 0; i < HistDepth; i++) begin
        if (i / MaxDims == int'(hd_nx)) begin
          hv_d[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q      <= '0;
      cv_q      <= '0;
      hd_q      <= '0;
      wcnt_q    <= '0;
      tap_v_q   <= 1'b0;
      bias_v_q  <= 1'b0;
      prod_op_q <= MUL_NONE;
    end else begin
      hv_q      <= hv_d;
      cv_q      <= cv_d;
      tap_v_q   <= cmd_i.tap_rd;
      bias_v_q  <= cmd_i.bias_rd;
      prod_op_q <= mop;
      if (sstart) begin
        wcnt_q <= '0;
      end else if (cmd_i.word_done) begin
        wcnt_q <= wcnt_q + 16'd1;
      end
      if (cmd_i.word_done) begin
        hd_q <= hd_nx;
      end
    end
  end

  // Shared multiplier operand selection.
  assign mop = tap_v_q ? MUL_TAP : cmd_i.mul_op;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop)
      MUL_TAP: begin
        mul_a = h_rv_q ? 18'(h_rd_q) : '0;
        mul_b = 17'(w_rd_q);
      end
      MUL_FC: begin
        mul_a = c_rv_q ? 18'(c_rd_q) : '0;
        mul_b = $signed({4'd0, f_q});
      end
      MUL_FZ: begin
        mul_a = 18'(z_q);
        mul_b = 17'sd4096 - $signed({4'd0, f_q});
      end
      MUL_CO: begin
        mul_a = 18'(cell_new_q);
        mul_b = $signed({4'd0, o_q});
      end
      MUL_CW: begin
        mul_a = 18'(co_q);
        mul_b = 17'(wo_rd_q);
      end
      default: ;
    endcase
  end

  assign acc_rnd = (acc_q + AW'(2048)) >>> 12;
  assign sum_rnd = (sum_q + SW'(2048)) >>> 12;
  assign acc_sat = (acc_rnd > AW'(32767)) ? 16'sh7FFF :
                   (acc_rnd < AW'(-32768)) ? 16'sh8000 : acc_rnd[15:0];
  assign sum_sat = (sum_rnd > SW'(32767)) ? 16'sh7FFF :
                   (sum_rnd < SW'(-32768)) ? 16'sh8000 : sum_rnd[15:0];

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (bias_v_q) begin
      acc_q <= AW'(b_rd_q) <<< 12;
    end else begin
      case (prod_op_q)
        MUL_TAP, MUL_FZ: acc_q <= acc_q + AW'(prod_q);
        MUL_FC, MUL_CO:  acc_q <= AW'(prod_q);
        default: ;
      endcase
    end
    if (is_elem && word_end_i) begin
      sum_q <= SW'(score_bias_i) <<< 12;
    end else if (prod_op_q == MUL_CW) begin
      sum_q <= sum_q + SW'(prod_q);
    end
    if (cmd_i.gate_rnd) begin
      x_q <= acc_sat;
    end else if (cmd_i.sum_rnd) begin
      x_q <= sum_sat;
    end
    if (cmd_i.gate_act) begin
      case (g_i)
        GATE_Z:  z_q <= tanh_q(x_q);
        GATE_F:  f_q <= sigmoid_q(x_q);
        GATE_O:  o_q <= sigmoid_q(x_q);
        default: ;
      endcase
    end
    if (cmd_i.cell_wr) begin
      cell_new_q <= acc_sat;
    end
    if (cmd_i.co_rnd) begin
      co_q <= acc_rnd[16:0];
    end
    if (cmd_i.out_load) begin
      score_q <= sigmoid_q(x_q);
      wn_q    <= wcnt_q;
    end
  end

  assign score_o       = score_q;
  assign word_number_o = wn_q;

endmodule

@@ hdl/qrnn_fo_pool_word_scorer_core.sv @@
// Top level of the QRNN fo-pooling word scorer with its register port.
//
// Input channel (valid/ready): each transaction carries an opcode, a slot, a
// value and two flags. Opcodes 0 to 2 write the conv weight, gate bias and
// output weight memories; opcode 3 delivers one embedding element of a word.
// A load or an element without word_end leaves the input ready. The element that
// carries word_end starts scoring, which runs through a single shared
// multiply-accumulate unit: per cell there are three gate sums of
// dims*width taps each plus fixed overhead.
// The input is not ready while a word is scored.
// Output channel (valid/ready): one transaction per word with the score and
// the word number. The result sits in an output register, so the next word's
// elements are taken while it waits; a stalled receiver only holds the block
// when the following score is ready to leave.
// Reset clears the history, cell state, word counter and registers to their
// defaults; the weight memories keep their contents and must be loaded first.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12.
module qrnn_fo_pool_word_scorer_core #(
  parameter int MaxDims   = qrnn_pkg::MAX_DIMS,
  parameter int MaxCells  = qrnn_pkg::MAX_CELLS,
  parameter int MaxWindow = qrnn_pkg::MAX_WINDOW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        slot_i,
  input  logic signed [15:0] value_i,
  input  logic               sentence_start_i,
  input  logic               word_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [12:0]        score_o,
  output logic [15:0]        word_number_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qrnn_pkg::*;

  localparam int KW  = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int CIW = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int WW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;

  logic [6:0]         dims_q, cells_q;
  logic [2:0]         window_q;
  logic signed [15:0] bias_q;
  logic               cfg_we;

  cmd_t           cmd;
  logic [CIW-1:0] c_idx;
  logic [1:0]     g_idx;
  logic [KW-1:0]  k_idx;
  logic [WW-1:0]  m_idx, age_idx;

  // The register port never waits; a write lands in its access cycle.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q   <= 7'd64;
      cells_q  <= 7'd64;
      window_q <= 3'd1;
      bias_q   <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_DIMS:   dims_q   <= pwdata[6:0];
        REG_CELLS:  cells_q  <= pwdata[6:0];
        REG_WINDOW: window_q <= pwdata[2:0];
        REG_BIAS:   bias_q   <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_DIMS:   prdata = {25'd0, dims_q};
      REG_CELLS:  prdata = {25'd0, cells_q};
      REG_WINDOW: prdata = {29'd0, window_q};
      REG_BIAS:   prdata = {16'd0, bias_q};
      default:    prdata = '0;
    endcase
  end

  qrnn_ctrl #(
    .MaxDims   (MaxDims),
    .MaxCells  (MaxCells),
    .MaxWindow (MaxWindow)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .word_end_i  (word_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dims_i      (dims_q),
    .cells_i     (cells_q),
    .window_i    (window_q),
    .cmd_o       (cmd),
    .c_o         (c_idx),
    .g_o         (g_idx),
    .k_o         (k_idx),
    .m_o         (m_idx),
    .age_o       (age_idx)
  );

  qrnn_dp #(
    .MaxDims   (MaxDims),
    .MaxCells  (MaxCells),
    .MaxWindow (MaxWindow)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .slot_i           (slot_i),
    .value_i          (value_i),
    .sentence_start_i (sentence_start_i),
    .word_end_i       (word_end_i),
    .score_bias_i     (bias_q),
    .c_i              (c_idx),
    .g_i              (g_idx),
    .k_i              (k_idx),
    .m_i              (m_idx),
    .age_i            (age_idx),
    .score_o          (score_o),
    .word_number_o    (word_number_o)
  );

endmodule

@@ hdl/qrnn_chk.sv @@
// Port-level checker of the QRNN word scorer and its bind.
module qrnn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic        word_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [12:0] score_o,
  input logic [15:0] word_number_o
);
  import qrnn_pkg::*;

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(score_o)
      && $stable(word_number_o))
    else $error("result changed while stalled");

  // A sigmoid never exceeds one.
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_o <= 13'd4096)
    else $error("score out of range");

  // Loads and inner elements leave the input ready.
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !(opcode_i == OP_ELEM && word_end_i) |=> in_ready_o)
    else $error("input stalled after a short transaction");

  // The last element of a word starts scoring, which blocks the input.
  a_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_ELEM && word_end_i |=> !in_ready_o)
    else $error("input ready while a word is scored");

endmodule

bind qrnn_fo_pool_word_scorer_core qrnn_chk u_qrnn_chk (.*);
